// ----- hw/rtl/dfcc_pkg.sv -----
// Shared types, constants and the CRC step for the delimited frame CRC checker.
package dfcc_pkg;

   localparam int BODY_DEPTH_DEF    = 64;
   localparam int PATTERN_BYTES_DEF = 8;
   localparam int LEN_BITS          = 4;
   localparam int CSR_DATA_W        = 64;
   localparam int CSR_ADDR_W        = 5;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   typedef enum logic [1:0] {
      KIND_DATA     = 2'd0,
      KIND_EMPTY    = 2'd1,
      KIND_CRC_ERR  = 2'd2,
      KIND_OVERFLOW = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      REG_HEAD_PATTERN = 2'd0,
      REG_HEAD_LEN     = 2'd1,
      REG_TAIL_PATTERN = 2'd2,
      REG_TAIL_LEN     = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

   typedef struct packed {
      logic [LEN_BITS-1:0] head_len;
      logic [LEN_BITS-1:0] tail_len;
   } cell_cfg_type;

   typedef struct packed {
      logic head;
      logic tail;
   } cell_hit_type;

   // CRC-16/MODBUS over one byte, LSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ----- hw/rtl/dfcc_req_if.sv -----
// Input byte channel.
interface dfcc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- hw/rtl/dfcc_rsp_if.sv -----
// Result channel.
interface dfcc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] data_byte;
   logic       last;

   modport source (output valid, output kind, output data_byte, output last, input ready);
   modport sink   (input valid, input kind, input data_byte, input last, output ready);
endinterface

// ----- hw/rtl/dfcc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module dfcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ----- hw/rtl/dfcc_cell.sv -----
// One window cell: holds one received byte and compares the incoming one against both patterns.
module dfcc_cell #(
   parameter int INDEX         = 0,
   parameter int PATTERN_BYTES = dfcc_pkg::PATTERN_BYTES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  dfcc_pkg::cell_ctrl_type      ctrl,
   input  dfcc_pkg::cell_cfg_type       cfg,
   input  logic [PATTERN_BYTES*8-1:0]   head_pattern,
   input  logic [PATTERN_BYTES*8-1:0]   tail_pattern,
   input  logic [7:0]                   shift_byte,
   output logic [7:0]                   window_byte,
   output dfcc_pkg::cell_hit_type       hit
);
   import dfcc_pkg::*;

   logic [7:0]          win_ff, win_in;
   logic [LEN_BITS-1:0] head_pos, tail_pos;
   logic [7:0]          head_sel, tail_sel;
   logic                head_used, tail_used;

   // Cell k sits at age k of the window, so it faces pattern byte len-1-k
   always_comb begin
      head_pos  = cfg.head_len - LEN_BITS'(INDEX + 1);
      tail_pos  = cfg.tail_len - LEN_BITS'(INDEX + 1);
      head_used = cfg.head_len > LEN_BITS'(INDEX);
      tail_used = cfg.tail_len > LEN_BITS'(INDEX);
      head_sel  = 8'h00;
      tail_sel  = 8'h00;
      for (int j = 0; j < PATTERN_BYTES; j++) begin
         if (head_pos == LEN_BITS'(j)) begin
            head_sel = head_pattern[j*8 +: 8];
         end
         if (tail_pos == LEN_BITS'(j)) begin
            tail_sel = tail_pattern[j*8 +: 8];
         end
      end
      hit.head = !head_used || (shift_byte == head_sel);
      hit.tail = !tail_used || (shift_byte == tail_sel);
   end

   always_comb begin
      win_in = win_ff;
      if (ctrl.clear) begin
         win_in = 8'h00;
      end else if (ctrl.shift) begin
         win_in = shift_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= 8'h00;
      end else begin
         win_ff <= win_in;
      end
   end

   assign window_byte = win_ff;
endmodule

// ----- hw/rtl/delimited_frame_crc_checker.sv -----
// Delimited frame receiver with CRC-16/MODBUS check: top level.
// Takes at most one byte per cycle while its output register is free; a head match holds
// the input while the CRC step folds in the head bytes. A pass-through byte or a status
// item appears the cycle after its byte; after the CRC high byte a good frame emits its body RAM
// payload one byte per cycle while taken, via a RAM read and the output register; input held.
// Synchronous reset clears the configuration, the frame state and the window.
module delimited_frame_crc_checker #(
   parameter int BODY_DEPTH    = dfcc_pkg::BODY_DEPTH_DEF,
   parameter int PATTERN_BYTES = dfcc_pkg::PATTERN_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   dfcc_req_if.sink                          req_if,
   dfcc_rsp_if.source                        rsp_if,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [dfcc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [dfcc_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [dfcc_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import dfcc_pkg::*;

   localparam int CNT_W  = $clog2(BODY_DEPTH + 1);
   localparam int ADDR_W = $clog2(BODY_DEPTH);
   localparam int PAT_W  = PATTERN_BYTES * 8;

   typedef enum logic [5:0] {
      ST_HUNT     = 6'b000001,
      ST_HEAD_CRC = 6'b000010,
      ST_BODY     = 6'b000100,
      ST_CRC_LO   = 6'b001000,
      ST_CRC_HI   = 6'b010000,
      ST_EMIT     = 6'b100000
   } state_type;

   // configuration
   logic [CSR_DATA_W-1:0] head_pattern_ff, tail_pattern_ff;
   logic [LEN_BITS-1:0]   head_len_ff, tail_len_ff;
   logic [LEN_BITS-1:0]   hl_eff, tl_eff;
   logic                  pass_thru;
   reg_index_type         csr_idx;
   logic                  csr_wr;

   // frame state
   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    bsh_ff, bsh_in, bsh_inc, hunt_cnt;
   logic [CNT_W-1:0]    body_len_ff, body_len_in;
   logic [15:0]         crc_ff, crc_in;
   logic [7:0]          crc_lo_ff, crc_lo_in;
   logic [LEN_BITS-1:0] hcnt_ff, hcnt_in;
   logic [7:0]          head_byte_sel;
   logic [CNT_W-1:0]    issue_ff, issue_in, emitted_ff, emitted_in;
   logic                rdv_ff, rdv_in;

   // output register
   logic     rsp_valid_ff, rsp_valid_in;
   kind_type out_kind_ff, out_kind_in;
   logic [7:0] out_data_ff, out_data_in;
   logic     out_last_ff, out_last_in;
   logic     out_load, out_free, accept, out_take;

   // window chain and body store
   cell_ctrl_type cell_ctrl;
   cell_cfg_type  cell_cfg;
   cell_hit_type  hits [PATTERN_BYTES];
   logic [7:0]    chain [PATTERN_BYTES];
   logic          head_hit_all, tail_hit_all, head_match, tail_match;
   logic          ram_we, ram_re;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [7:0]    ram_rdata;

   // ---------------- configuration port ----------------
   assign pready  = 1'b1;
   assign csr_idx = reg_index_type'(paddr[4:3]);
   assign csr_wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_pattern_ff <= '0;
         head_len_ff     <= '0;
         tail_pattern_ff <= '0;
         tail_len_ff     <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_HEAD_PATTERN: head_pattern_ff <= pwdata;
            REG_HEAD_LEN:     head_len_ff     <= pwdata[LEN_BITS-1:0];
            REG_TAIL_PATTERN: tail_pattern_ff <= pwdata;
            REG_TAIL_LEN:     tail_len_ff     <= pwdata[LEN_BITS-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_HEAD_PATTERN: prdata = head_pattern_ff;
         REG_HEAD_LEN:     prdata = CSR_DATA_W'(head_len_ff);
         REG_TAIL_PATTERN: prdata = tail_pattern_ff;
         REG_TAIL_LEN:     prdata = CSR_DATA_W'(tail_len_ff);
      endcase
   end

   // clamp lengths to the window size
   assign hl_eff = (head_len_ff > LEN_BITS'(PATTERN_BYTES)) ? LEN_BITS'(PATTERN_BYTES)
                                                          : head_len_ff;
   assign tl_eff = (tail_len_ff > LEN_BITS'(PATTERN_BYTES)) ? LEN_BITS'(PATTERN_BYTES)
                                                          : tail_len_ff;
   assign pass_thru = (hl_eff == '0) || (tl_eff == '0);

   // ---------------- window cells ----------------
   assign cell_cfg.head_len = hl_eff;
   assign cell_cfg.tail_len = tl_eff;
   assign chain[0] = req_if.rx_byte;

   for (genvar k = 0; k < PATTERN_BYTES; k++) begin : g_cell
      if (k < PATTERN_BYTES - 1) begin : g_mid
         dfcc_cell #(.INDEX(k), .PATTERN_BYTES(PATTERN_BYTES)) u_cell (
            .clock        (clock),
            .reset        (reset),
            .ctrl         (cell_ctrl),
            .cfg          (cell_cfg),
            .head_pattern (head_pattern_ff[PAT_W-1:0]),
            .tail_pattern (tail_pattern_ff[PAT_W-1:0]),
            .shift_byte   (chain[k]),
            .window_byte  (chain[k+1]),
            .hit          (hits[k])
         );
      end else begin : g_end
         dfcc_cell #(.INDEX(k), .PATTERN_BYTES(PATTERN_BYTES)) u_cell (
            .clock        (clock),
            .reset        (reset),
            .ctrl         (cell_ctrl),
            .cfg          (cell_cfg),
            .head_pattern (head_pattern_ff[PAT_W-1:0]),
            .tail_pattern (tail_pattern_ff[PAT_W-1:0]),
            .shift_byte   (chain[k]),
            .window_byte  (),
            .hit          (hits[k])
         );
      end
   end

   always_comb begin
      head_hit_all = 1'b1;
      tail_hit_all = 1'b1;
      for (int k = 0; k < PATTERN_BYTES; k++) begin
         head_hit_all = head_hit_all && hits[k].head;
         tail_hit_all = tail_hit_all && hits[k].tail;
      end
   end

   // ---------------- body store ----------------
   dfcc_ram #(.WIDTH(8), .DEPTH(BODY_DEPTH)) u_body_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (req_if.rx_byte),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // ---------------- control ----------------
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = out_free && (state_ff == ST_HUNT || state_ff == ST_BODY ||
                                      state_ff == ST_CRC_LO || state_ff == ST_CRC_HI);
   assign accept   = req_if.valid && req_if.ready;
   assign out_take = rdv_ff && out_free;

   assign bsh_inc    = bsh_ff + CNT_W'(1);
   assign hunt_cnt   = (bsh_ff < CNT_W'(PATTERN_BYTES)) ? bsh_inc : bsh_ff;
   assign head_match = head_hit_all && (hunt_cnt >= CNT_W'(hl_eff));
   assign tail_match = tail_hit_all && (bsh_inc >= CNT_W'(tl_eff));

   always_comb begin
      head_byte_sel = 8'h00;
      for (int j = 0; j < PATTERN_BYTES; j++) begin
         if (hcnt_ff == LEN_BITS'(j)) begin
            head_byte_sel = head_pattern_ff[j*8 +: 8];
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      bsh_in      = bsh_ff;
      body_len_in = body_len_ff;
      crc_in      = crc_ff;
      crc_lo_in   = crc_lo_ff;
      hcnt_in     = hcnt_ff;
      issue_in    = issue_ff;
      emitted_in  = emitted_ff;
      rdv_in      = rdv_ff;
      cell_ctrl   = '0;
      ram_we      = 1'b0;
      ram_waddr   = bsh_ff[ADDR_W-1:0];
      ram_re      = 1'b0;
      ram_raddr   = issue_ff[ADDR_W-1:0];
      out_load    = 1'b0;
      out_kind_in = KIND_DATA;
      out_data_in = 8'h00;
      out_last_in = 1'b1;

      if (accept && pass_thru) begin
         // drop any partial frame, hand the byte straight on
         state_in        = ST_HUNT;
         bsh_in          = '0;
         crc_in          = CRC_INIT;
         crc_lo_in       = 8'h00;
         cell_ctrl.clear = 1'b1;
         out_load        = 1'b1;
         out_data_in     = req_if.rx_byte;
      end else begin
         unique case (state_ff)
            ST_HUNT: begin
               if (accept) begin
                  cell_ctrl.shift = 1'b1;
                  bsh_in          = hunt_cnt;
                  if (head_match) begin
                     state_in    = ST_HEAD_CRC;
                     crc_in      = CRC_INIT;
                     hcnt_in     = '0;
                     bsh_in      = '0;
                     body_len_in = '0;
                  end
               end
            end
            ST_HEAD_CRC: begin
               // fold in one head byte a cycle
               crc_in  = crc_byte(crc_ff, head_byte_sel);
               hcnt_in = hcnt_ff + LEN_BITS'(1);
               if (hcnt_ff == hl_eff - LEN_BITS'(1)) begin
                  state_in = ST_BODY;
               end
            end
            ST_BODY: begin
               if (accept) begin
                  cell_ctrl.shift = 1'b1;
                  crc_in          = crc_byte(crc_ff, req_if.rx_byte);
                  ram_we          = bsh_ff < CNT_W'(BODY_DEPTH);
                  bsh_in          = bsh_inc;
                  if (tail_match) begin
                     body_len_in = bsh_inc - CNT_W'(tl_eff);
                     state_in    = ST_CRC_LO;
                  end else if (bsh_inc >= CNT_W'(BODY_DEPTH)) begin
                     state_in        = ST_HUNT;
                     bsh_in          = '0;
                     crc_in          = CRC_INIT;
                     crc_lo_in       = 8'h00;
                     cell_ctrl.clear = 1'b1;
                     out_load        = 1'b1;
                     out_kind_in     = KIND_OVERFLOW;
                  end
               end
            end
            ST_CRC_LO: begin
               if (accept) begin
                  cell_ctrl.shift = 1'b1;
                  crc_lo_in       = req_if.rx_byte;
                  state_in        = ST_CRC_HI;
               end
            end
            ST_CRC_HI: begin
               if (accept) begin
                  state_in        = ST_HUNT;
                  bsh_in          = '0;
                  crc_in          = CRC_INIT;
                  crc_lo_in       = 8'h00;
                  cell_ctrl.clear = 1'b1;
                  if ({req_if.rx_byte, crc_lo_ff} != crc_ff) begin
                     out_load    = 1'b1;
                     out_kind_in = KIND_CRC_ERR;
                  end else if (body_len_ff == '0) begin
                     out_load    = 1'b1;
                     out_kind_in = KIND_EMPTY;
                  end else begin
                     state_in   = ST_EMIT;
                     issue_in   = '0;
                     emitted_in = '0;
                     rdv_in     = 1'b0;
                  end
               end
            end
            ST_EMIT: begin
               if (out_take) begin
                  out_load    = 1'b1;
                  out_data_in = ram_rdata;
                  out_last_in = emitted_ff == body_len_ff - CNT_W'(1);
                  emitted_in  = emitted_ff + CNT_W'(1);
                  if (out_last_in) begin
                     state_in = ST_HUNT;
                  end
               end
               // keep one read in flight ahead of the output register
               if ((issue_ff < body_len_ff) && (!rdv_ff || out_take)) begin
                  ram_re   = 1'b1;
                  issue_in = issue_ff + CNT_W'(1);
                  rdv_in   = 1'b1;
               end else if (out_take) begin
                  rdv_in = 1'b0;
               end
            end
            default: begin
               state_in = ST_HUNT;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_HUNT;
         bsh_ff       <= '0;
         body_len_ff  <= '0;
         crc_ff       <= CRC_INIT;
         crc_lo_ff    <= 8'h00;
         hcnt_ff      <= '0;
         issue_ff     <= '0;
         emitted_ff   <= '0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bsh_ff       <= bsh_in;
         body_len_ff  <= body_len_in;
         crc_ff       <= crc_in;
         crc_lo_ff    <= crc_lo_in;
         hcnt_ff      <= hcnt_in;
         issue_ff     <= issue_in;
         emitted_ff   <= emitted_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_kind_ff <= out_kind_in;
         out_data_ff <= out_data_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.kind      = out_kind_ff;
   assign rsp_if.data_byte = out_data_ff;
   assign rsp_if.last      = out_last_ff;
endmodule

// ----- hw/rtl/dfcc_checker.sv -----
// Port-level assertions for the delimited frame CRC checker, bound to the top level.
module dfcc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic [7:0]                      req_rx_byte,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [1:0]                      rsp_kind,
   input logic [7:0]                      rsp_data_byte,
   input logic                            rsp_last,
   input logic                            psel,
   input logic                            penable,
   input logic                            pwrite,
   input logic [dfcc_pkg::CSR_ADDR_W-1:0] paddr,
   input logic [dfcc_pkg::CSR_DATA_W-1:0] pwdata
);
   import dfcc_pkg::*;

   logic [LEN_BITS-1:0] hl_ff, tl_ff;
   logic                pass_thru;

   // track the pattern lengths from the write transactions
   always_ff @(posedge clock) begin
      if (reset) begin
         hl_ff <= '0;
         tl_ff <= '0;
      end else if (psel && penable && pwrite) begin
         if (paddr[4:3] == REG_HEAD_LEN) begin
            hl_ff <= pwdata[LEN_BITS-1:0];
         end
         if (paddr[4:3] == REG_TAIL_LEN) begin
            tl_ff <= pwdata[LEN_BITS-1:0];
         end
      end
   end

   assign pass_thru = (hl_ff == '0) || (tl_ff == '0);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
         $stable(rsp_data_byte) && $stable(rsp_last))
      else $error("result transaction changed while stalled");

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("byte taken while a result is stalled");

   a_pass_thru: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && pass_thru |=>
         rsp_valid && rsp_kind == KIND_DATA && rsp_last &&
         rsp_data_byte == $past(req_rx_byte))
      else $error("pass-through byte not forwarded next cycle");

   a_status_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_DATA |-> rsp_last && rsp_data_byte == 8'h00)
      else $error("status transaction not marked last or data not zero");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind delimited_frame_crc_checker dfcc_checker u_dfcc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .req_rx_byte   (req_if.rx_byte),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_kind      (rsp_if.kind),
   .rsp_data_byte (rsp_if.data_byte),
   .rsp_last      (rsp_if.last),
   .psel          (psel),
   .penable       (penable),
   .pwrite        (pwrite),
   .paddr         (paddr),
   .pwdata        (pwdata)
);

// ----- tb/delimited_frame_crc_checker_tb.sv -----
// Self-checking testbench for the delimited frame CRC checker: directed table, then random frames.
module delimited_frame_crc_checker_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dfcc_pkg::*;

   localparam int DEPTH         = BODY_DEPTH_DEF;
   localparam int PAT_BYTES     = PATTERN_BYTES_DEF;
   localparam int SETTLE        = 32;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int LONG_HOLD     = 300;
   localparam int HOLD_BACKLOG  = 40;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_BYTES   = 4;

   typedef enum logic [1:0] {SCAN_HEAD, SCAN_BODY, SCAN_CRC_LO, SCAN_CRC_HI} scan_state_type;
   typedef enum logic [2:0] {OP_WRITE, OP_BYTE, OP_CRC_LO, OP_CRC_HI, OP_CRC_BAD} row_op_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data_byte;
      logic       last;
   } frame_result_type;

   typedef struct {
      row_op_type       op;
      reg_index_type    reg_sel;
      logic [63:0]      value;
      bit               typed;
      frame_result_type want;
   } stim_row_type;

   localparam frame_result_type NO_RESULT = '{kind: KIND_DATA, data_byte: 8'h00, last: 1'b0};

   // Head 55 AA, tail 0A 0D; upper pattern bytes are junk that must be ignored
   stim_row_type directed_rows [32] = '{
      '{OP_BYTE,  REG_HEAD_PATTERN, 64'h00, 1'b1, '{KIND_DATA, 8'h00, 1'b1}},
      '{OP_BYTE,  REG_HEAD_PATTERN, 64'hFF, 1'b1, '{KIND_DATA, 8'hFF, 1'b1}},
      '{OP_WRITE, REG_HEAD_PATTERN, 64'h0123_4567_89AB_AA55, 1'b0, NO_RESULT},
      '{OP_WRITE, REG_HEAD_LEN,     64'd2, 1'b0, NO_RESULT},
      '{OP_WRITE, REG_TAIL_PATTERN, 64'hFFFF_FFFF_FFFF_0D0A, 1'b0, NO_RESULT},
      '{OP_WRITE, REG_TAIL_LEN,     64'd2, 1'b0, NO_RESULT},
      '{OP_BYTE,    REG_HEAD_PATTERN, 64'h55, 1'b0, NO_RESULT},
      '{OP_BYTE,    REG_HEAD_PATTERN, 64'hAA, 1'b0, NO_RESULT},
      '{OP_BYTE,    REG_HEAD_PATTERN, 64'h00, 1'b0, NO_RESULT},
      '{OP_BYTE,    REG_HEAD_PATTERN, 64'hFF, 1'b0, NO_RESULT},
      '{OP_BYTE,    REG_HEAD_PATTERN, 64'h0A, 1'b0, NO_RESULT},
      '{OP_BYTE,    REG_HEAD_PATTERN, 64'h0D, 1'b0, NO_RESULT},
      '{OP_CRC_LO,  REG_HEAD_PATTERN, 64'h00, 1'b0, NO_RESULT},
      '{OP_CRC_HI,  REG_HEAD_PATTERN, 64'h00, 1'b0, NO_RESULT},
      '{OP_BYTE,    REG_HEAD_PATTERN, 64'h55, 1'b0, NO_RESULT},
      '{OP_BYTE,    REG_HEAD_PATTERN, 64'hAA, 1'b0, NO_RESULT},
      '{OP_BYTE,    REG_HEAD_PATTERN, 64'h0A, 1'b0, NO_RESULT},
      '{OP_BYTE,    REG_HEAD_PATTERN, 64'h0D, 1'b0, NO_RESULT},
      '{OP_CRC_LO,  REG_HEAD_PATTERN, 64'h00, 1'b0, NO_RESULT},
      '{OP_CRC_HI,  REG_HEAD_PATTERN, 64'h00, 1'b1, '{KIND_EMPTY, 8'h00, 1'b1}},
      '{OP_BYTE,    REG_HEAD_PATTERN, 64'h55, 1'b0, NO_RESULT},
      '{OP_BYTE,    REG_HEAD_PATTERN, 64'hAA, 1'b0, NO_RESULT},
      '{OP_BYTE,    REG_HEAD_PATTERN, 64'h0A, 1'b0, NO_RESULT},
      '{OP_BYTE,    REG_HEAD_PATTERN, 64'h0D, 1'b0, NO_RESULT},
      '{OP_CRC_LO,  REG_HEAD_PATTERN, 64'h00, 1'b0, NO_RESULT},
      '{OP_CRC_BAD, REG_HEAD_PATTERN, 64'h00, 1'b1, '{KIND_CRC_ERR, 8'h00, 1'b1}},
      // drop a half-received frame by switching to pass-through mid-body
      '{OP_BYTE,  REG_HEAD_PATTERN, 64'h55, 1'b0, NO_RESULT},
      '{OP_BYTE,  REG_HEAD_PATTERN, 64'hAA, 1'b0, NO_RESULT},
      '{OP_BYTE,  REG_HEAD_PATTERN, 64'h11, 1'b0, NO_RESULT},
      '{OP_WRITE, REG_TAIL_LEN,     64'd0,  1'b0, NO_RESULT},
      '{OP_BYTE,  REG_HEAD_PATTERN, 64'h80, 1'b1, '{KIND_DATA, 8'h80, 1'b1}},
      '{OP_WRITE, REG_TAIL_LEN,     64'd2,  1'b0, NO_RESULT}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   dfcc_req_if req_if ();
   dfcc_rsp_if rsp_if ();

   delimited_frame_crc_checker i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #2 clock = ~clock;

   // predictor configuration and frame state
   logic [63:0] cfg_head_pat;
   logic [3:0]  cfg_head_len;
   logic [63:0] cfg_tail_pat;
   logic [3:0]  cfg_tail_len;

   scan_state_type scan_state;
   logic [63:0] byte_window;
   int          since_head;
   logic [15:0] frame_crc;
   logic [7:0]  body_mem [DEPTH];
   int          payload_len;
   logic [7:0]  crc_lo_byte;

   frame_result_type pending_results [$];
   frame_result_type fresh_results [$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   int bytes_sent     = 0;
   bit req_calm       = 1'b0;
   bit rsp_calm       = 1'b0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] acc;
      acc = crc ^ {8'h00, b};
      repeat (8) acc = (acc >> 1) ^ (acc[0] ? CRC_POLY : 16'h0000);
      return acc;
   endfunction

   function automatic int eff_len(input logic [3:0] len);
      return (len > PAT_BYTES) ? PAT_BYTES : int'(len);
   endfunction

   // oldest pattern byte sits deepest in the window
   function automatic bit window_holds(input logic [63:0] pat, input int len);
      for (int i = 0; i < len; i++) begin
         if (pat[8*i +: 8] != byte_window[8*(len-1-i) +: 8]) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic void restart_scan();
      scan_state  = SCAN_HEAD;
      byte_window = '0;
      since_head  = 0;
      frame_crc   = CRC_INIT;
      payload_len = 0;
      crc_lo_byte = '0;
   endfunction

   function automatic void frame_step(input logic [7:0] b);
      int          hl;
      int          tl;
      logic [15:0] received;
      fresh_results.delete();
      hl = eff_len(cfg_head_len);
      tl = eff_len(cfg_tail_len);
      if (hl == 0 || tl == 0) begin
         restart_scan();
         fresh_results.push_back('{KIND_DATA, b, 1'b1});
         return;
      end
      byte_window = {byte_window[55:0], b};
      case (scan_state)
         SCAN_HEAD: begin
            if (since_head < PAT_BYTES) since_head++;
            if (since_head >= hl && window_holds(cfg_head_pat, hl)) begin
               frame_crc = CRC_INIT;
               for (int i = 0; i < hl; i++) begin
                  frame_crc = crc_fold(frame_crc, cfg_head_pat[8*i +: 8]);
               end
               since_head  = 0;
               payload_len = 0;
               scan_state  = SCAN_BODY;
            end
         end
         SCAN_BODY: begin
            frame_crc = crc_fold(frame_crc, b);
            if (since_head < DEPTH) body_mem[since_head] = b;
            since_head++;
            if (since_head >= tl && window_holds(cfg_tail_pat, tl)) begin
               payload_len = since_head - tl;
               scan_state  = SCAN_CRC_LO;
            end else if (since_head >= DEPTH) begin
               restart_scan();
               fresh_results.push_back('{KIND_OVERFLOW, 8'h00, 1'b1});
            end
         end
         SCAN_CRC_LO: begin
            crc_lo_byte = b;
            scan_state  = SCAN_CRC_HI;
         end
         default: begin
            received = {b, crc_lo_byte};
            if (received != frame_crc) begin
               fresh_results.push_back('{KIND_CRC_ERR, 8'h00, 1'b1});
            end else if (payload_len == 0) begin
               fresh_results.push_back('{KIND_EMPTY, 8'h00, 1'b1});
            end else begin
               for (int i = 0; i < payload_len; i++) begin
                  fresh_results.push_back('{KIND_DATA, body_mem[i], i + 1 == payload_len});
               end
            end
            restart_scan();
         end
      endcase
   endfunction

   // idle gap per transaction, with occasional stretches of back-to-back traffic
   function automatic int idle_cycles(ref bit calm);
      if ($urandom_range(0, 11) == 0) calm = !calm;
      return calm ? 0 : $urandom_range(0, 8);
   endfunction

   function automatic logic [3:0] pick_len();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0) return 4'd0;
      if (r < 3) return 4'($urandom_range(9, 15));
      return 4'($urandom_range(1, 8));
   endfunction

   task automatic flag_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic send_byte(input logic [7:0] b, input bit typed, input frame_result_type want);
      int gap;
      gap = idle_cycles(req_calm);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.rx_byte <= b;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      frame_step(b);
      if (typed) begin
         pending_results.push_back(want);
      end else begin
         foreach (fresh_results[i]) pending_results.push_back(fresh_results[i]);
      end
      bytes_sent++;
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [63:0] value);
      req_if.valid <= 1'b0;
      // hold until the block has drained and finished folding any head
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1) @(posedge clock);
      case (idx)
         REG_HEAD_PATTERN: cfg_head_pat = value;
         REG_HEAD_LEN:     cfg_head_len = value[3:0];
         REG_TAIL_PATTERN: cfg_tail_pat = value;
         default:          cfg_tail_len = value[3:0];
      endcase
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic send_frame(input int payload_bytes, input bit bad_crc, input bit broken_head,
                             input bit clean, input bit truncated);
      int         hl;
      int         tl;
      logic [7:0] b;
      logic [7:0] tail_end;
      hl = eff_len(cfg_head_len);
      tl = eff_len(cfg_tail_len);
      tail_end = (tl > 0) ? cfg_tail_pat[8*(tl-1) +: 8] : 8'h00;
      for (int i = 0; i < hl; i++) begin
         b = cfg_head_pat[8*i +: 8];
         if (broken_head && i == hl - 1) b = ~b;
         send_byte(b, 1'b0, NO_RESULT);
      end
      // keep a clean payload from closing the frame early
      for (int i = 0; i < payload_bytes; i++) begin
         b = 8'($urandom_range(0, 255));
         if (clean && tl > 0 && b == tail_end) b = ~b;
         send_byte(b, 1'b0, NO_RESULT);
      end
      if (!truncated) begin
         for (int i = 0; i < tl; i++) send_byte(cfg_tail_pat[8*i +: 8], 1'b0, NO_RESULT);
         send_byte(frame_crc[7:0], 1'b0, NO_RESULT);
         send_byte(bad_crc ? ~frame_crc[15:8] : frame_crc[15:8], 1'b0, NO_RESULT);
      end
   endtask

   initial begin
      int               gap;
      bit               held;
      frame_result_type want;
      held = 1'b0;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         gap = idle_cycles(rsp_calm);
         // one long hold inside a long payload burst, so the block backs up and stalls its input
         if (!held && pending_results.size() >= HOLD_BACKLOG) begin
            gap  = LONG_HOLD;
            held = 1'b1;
         end
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (rsp_if.valid !== 1'b1) @(posedge clock);
         if (pending_results.size() == 0) begin
            flag_mismatch($sformatf("unexpected result: kind %0d data %02h last %0b",
                                    rsp_if.kind, rsp_if.data_byte, rsp_if.last));
         end else begin
            want = pending_results.pop_front();
            if (rsp_if.kind !== want.kind) begin
               flag_mismatch($sformatf("kind %0d, expected %0d", rsp_if.kind, want.kind));
            end
            if (rsp_if.data_byte !== want.data_byte) begin
               flag_mismatch($sformatf("data_byte %02h, expected %02h",
                                       rsp_if.data_byte, want.data_byte));
            end
            if (rsp_if.last !== want.last) begin
               flag_mismatch($sformatf("last %0b, expected %0b", rsp_if.last, want.last));
            end
         end
      end
   end

   initial begin
      int          phase_start;
      int          shape;
      logic [3:0]  hl_val;
      logic [3:0]  tl_val;
      logic [63:0] hp_val;
      logic [63:0] tp_val;

      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.rx_byte <= 8'h00;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= '0;
      pwdata         <= '0;
      cfg_head_pat = '0;
      cfg_head_len = '0;
      cfg_tail_pat = '0;
      cfg_tail_len = '0;
      restart_scan();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         case (directed_rows[r].op)
            OP_WRITE:   write_reg(directed_rows[r].reg_sel, directed_rows[r].value);
            OP_BYTE:    send_byte(directed_rows[r].value[7:0], directed_rows[r].typed,
                                  directed_rows[r].want);
            OP_CRC_LO:  send_byte(frame_crc[7:0], directed_rows[r].typed, directed_rows[r].want);
            OP_CRC_HI:  send_byte(frame_crc[15:8], directed_rows[r].typed, directed_rows[r].want);
            default:    send_byte(~frame_crc[15:8], directed_rows[r].typed,
                                  directed_rows[r].want);
         endcase
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         hp_val = {$urandom, $urandom};
         tp_val = {$urandom, $urandom};
         case (p)
            0: begin
               hl_val = 4'd8;
               tl_val = 4'd8;
            end
            1: begin
               // lengths above the pattern width clamp to it
               hl_val = 4'd15;
               tl_val = 4'd9;
               hp_val = '1;
               tp_val = '0;
            end
            2: begin
               hl_val = 4'd1;
               tl_val = 4'd2;
            end
            3: begin
               hl_val = 4'd3;
               tl_val = 4'd1;
            end
            default: begin
               hl_val = pick_len();
               tl_val = pick_len();
            end
         endcase
         write_reg(REG_HEAD_PATTERN, hp_val);
         write_reg(REG_HEAD_LEN, 64'(hl_val));
         write_reg(REG_TAIL_PATTERN, tp_val);
         write_reg(REG_TAIL_LEN, 64'(tl_val));

         if (p == 2) send_frame(DEPTH, 1'b0, 1'b0, 1'b1, 1'b0);
         if (p == 3) send_frame(DEPTH - 1, 1'b0, 1'b0, 1'b1, 1'b0);

         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            shape = $urandom_range(0, 9);
            if (shape == 0) begin
               repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)), 1'b0,
                                                       NO_RESULT);
            end else begin
               send_frame($urandom_range(0, 10), $urandom_range(0, 4) == 0, shape == 1,
                          $urandom_range(0, 7) != 0, shape == 2);
            end
         end
      end

      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/dfcc_pkg.sv
hw/rtl/dfcc_req_if.sv
hw/rtl/dfcc_rsp_if.sv
hw/rtl/dfcc_ram.sv
hw/rtl/dfcc_cell.sv
hw/rtl/delimited_frame_crc_checker.sv
hw/rtl/dfcc_checker.sv
tb/delimited_frame_crc_checker_tb.sv
